@@ src/rwps_pkg.sv @@
package rwps_pkg;

	localparam int MAX_WAVES    = 16;
	localparam int IDX_W        = (MAX_WAVES > 1) ? $clog2(MAX_WAVES) : 1;
	localparam int CNT_W        = $clog2(MAX_WAVES + 1);
	localparam int CORDIC_STEPS = 14;
	localparam int ITER_W       = $clog2(CORDIC_STEPS);
	localparam int CW           = 34;
	localparam int ACC_W        = 35 + IDX_W;

	localparam logic signed [CW-1:0] CORDIC_X0 = 34'sd652032874;
	localparam logic signed [5:0]    COUNT_LIMIT = 6'sd16;

	localparam logic [13:0] STEP_ANGLE [CORDIC_STEPS] = '{
		14'd8192, 14'd4836, 14'd2555, 14'd1297, 14'd651, 14'd326, 14'd163,
		14'd81, 14'd41, 14'd20, 14'd10, 14'd5, 14'd3, 14'd1
	};

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_PREP,
		ST_ROT,
		ST_SINE,
		ST_SCALE,
		ST_TERM,
		ST_ACC,
		ST_DONE
	} state_t;

	typedef enum logic [0:0] {
		REG_WAVE_COUNT = 1'b0,
		REG_TERM_SCALE = 1'b1
	} reg_idx_t;

	function automatic logic signed [5:0] clamp_count(input logic signed [31:0] v);
		logic signed [5:0] r;
		if (v > 32'sd16) begin
			r = COUNT_LIMIT;
		end else if (v < -32'sd16) begin
			r = -COUNT_LIMIT;
		end else begin
			r = v[5:0];
		end
		return r;
	endfunction

endpackage

@@ src/random_wave_potential_sum.sv @@
// Sum of plane waves evaluated at a position, one component of a potential.
// Configuration is written over the APB port (wave_count at 0x0, term_scale
// at 0x4); it is to be written only while the block is idle, which the block
// itself does not enforce. pready is always high. A request on the input
// channel with kind 0 loads one wave entry; it produces no result. A request
// with kind 1 evaluates the potential and produces exactly one result on the
// output channel. An evaluation walks the active entries, the first n where
// n is wave_count limited to the table size, one after another through a
// single CORDIC shift-add unit (14 rotations) and a single shared multiplier.
// in_stall stays high from the accepted request until the result has gone
// into the output register.
// The result is held in an output register. While the receiver stalls, the
// block still accepts a new request, but a finished evaluation waits until
// the output register is free.
// Reset marks every wave entry empty (an empty entry reads as zero), restores
// the register defaults and drops out_valid.
module random_wave_potential_sum import rwps_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                kind,
	input  logic [3:0]          wave_index,
	input  logic signed [31:0]  vec_a_x,
	input  logic signed [31:0]  vec_a_y,
	input  logic signed [31:0]  vec_a_z,
	input  logic signed [15:0]  vec_b_x,
	input  logic signed [15:0]  vec_b_y,
	input  logic signed [15:0]  vec_b_z,
	input  logic [15:0]         phase_turns,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [31:0]  potential
);

	state_t state_q, state_d;

	logic [4:0]  wave_count_q;
	logic [15:0] term_scale_q;

	logic [MAX_WAVES-1:0] valid_q;
	logic [17:0] cnt_mem [MAX_WAVES];
	logic [47:0] amp_mem [MAX_WAVES];
	logic [15:0] phs_mem [MAX_WAVES];

	logic [17:0] ent_cnt_q;
	logic [47:0] ent_amp_q;
	logic [15:0] ent_phs_q;

	logic [15:0] pos_q [3];
	logic [15:0] dir_q [3];

	logic [CNT_W-1:0] n_q, m_q, n_d;
	logic [ITER_W-1:0] it_q;

	logic signed [CW-1:0] x_q, y_q;
	logic signed [17:0]   z_q;
	logic signed [32:0]   dot_q;
	logic signed [15:0]   sine_q;
	logic signed [65:0]   mul_q;
	logic [ACC_W-1:0]     acc_q;

	logic        out_valid_q;
	logic [31:0] potential_q;

	logic load_fire, eval_fire, done_fire, last_wave, cfg_write;
	logic signed [32:0] mul_a, mul_b;
	logic [15:0] ph;
	logic signed [17:0] t18, tf;
	logic signed [CW-1:0] sx, sy, rnd;
	logic signed [17:0] ang;
	logic signed [15:0] sine_d;
	logic [ACC_W-1:0] term_ext;
	logic [31:0] sat;
	logic [1:0] jsel;
	reg_idx_t reg_idx;

	assign pready    = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign load_fire = in_valid && !in_stall && !kind;
	assign eval_fire = in_valid && !in_stall && kind;
	assign done_fire = (state_q == ST_DONE) && (!out_valid_q || !out_stall);
	assign last_wave = (({1'b0, m_q} + 1'b1) == {1'b0, n_q});
	assign cfg_write = psel && penable && pwrite && pready;
	assign reg_idx   = reg_idx_t'(paddr[2]);
	assign out_valid = out_valid_q;
	assign potential = potential_q;

	assign n_d = (32'(wave_count_q) > MAX_WAVES) ? CNT_W'(MAX_WAVES) : CNT_W'(wave_count_q);

	always_comb begin
		unique case (reg_idx)
			REG_WAVE_COUNT: prdata = {27'd0, wave_count_q};
			REG_TERM_SCALE: prdata = {16'd0, term_scale_q};
			default:        prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_count_q <= 5'd10;
			term_scale_q <= 16'd6554;
		end else if (cfg_write) begin
			unique case (reg_idx)
				REG_WAVE_COUNT: wave_count_q <= pwdata[4:0];
				REG_TERM_SCALE: term_scale_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (eval_fire) begin
					state_d = (n_d == '0) ? ST_DONE : ST_READ;
				end
			end
			ST_READ:  state_d = ST_PREP;
			ST_PREP:  state_d = ST_ROT;
			ST_ROT: begin
				if (it_q == ITER_W'(CORDIC_STEPS - 1)) begin
					state_d = ST_SINE;
				end
			end
			ST_SINE:  state_d = ST_SCALE;
			ST_SCALE: state_d = ST_TERM;
			ST_TERM:  state_d = ST_ACC;
			ST_ACC:   state_d = last_wave ? ST_DONE : ST_READ;
			ST_DONE: begin
				if (done_fire) begin
					state_d = ST_IDLE;
				end
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Wave table.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (load_fire && (32'(wave_index) < MAX_WAVES)) begin
			valid_q[IDX_W'(wave_index)] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_fire && (32'(wave_index) < MAX_WAVES)) begin
			cnt_mem[IDX_W'(wave_index)] <= {clamp_count(vec_a_z), clamp_count(vec_a_y),
				clamp_count(vec_a_x)};
			amp_mem[IDX_W'(wave_index)] <= {vec_b_z, vec_b_y, vec_b_x};
			phs_mem[IDX_W'(wave_index)] <= phase_turns;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			if (valid_q[m_q[IDX_W-1:0]]) begin
				ent_cnt_q <= cnt_mem[m_q[IDX_W-1:0]];
				ent_amp_q <= amp_mem[m_q[IDX_W-1:0]];
				ent_phs_q <= phs_mem[m_q[IDX_W-1:0]];
			end else begin
				ent_cnt_q <= '0;
				ent_amp_q <= '0;
				ent_phs_q <= '0;
			end
		end
	end

	// Phase in turns, folded into a quarter turn either side of zero.
	always_comb begin
		ph = ent_phs_q
			+ 16'({{10{ent_cnt_q[5]}}, ent_cnt_q[5:0]} * pos_q[0])
			+ 16'({{10{ent_cnt_q[11]}}, ent_cnt_q[11:6]} * pos_q[1])
			+ 16'({{10{ent_cnt_q[17]}}, ent_cnt_q[17:12]} * pos_q[2]);
		t18 = {{2{ph[15]}}, ph};
		if (t18 > 18'sd16384) begin
			tf = 18'sd32768 - t18;
		end else if (t18 < -18'sd16384) begin
			tf = -18'sd32768 - t18;
		end else begin
			tf = t18;
		end
	end

	assign sx  = x_q >>> it_q;
	assign sy  = y_q >>> it_q;
	assign ang = signed'({4'd0, STEP_ANGLE[it_q]});
	assign rnd = (y_q + 34'sd16384) >>> 15;

	always_comb begin
		if (rnd > 34'sd32767) begin
			sine_d = 16'sh7fff;
		end else if (rnd < -34'sd32768) begin
			sine_d = -16'sh8000;
		end else begin
			sine_d = rnd[15:0];
		end
	end

	assign jsel = it_q[1:0];

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_ROT: begin
				if (it_q < ITER_W'(3)) begin
					mul_a = signed'({{17{ent_amp_q[16*jsel+15]}}, ent_amp_q[16*jsel +: 16]});
					mul_b = signed'({{17{dir_q[jsel][15]}}, dir_q[jsel]});
				end
			end
			ST_SCALE: begin
				mul_a = signed'({{17{sine_q[15]}}, sine_q});
				mul_b = signed'({17'd0, term_scale_q});
			end
			ST_TERM: begin
				mul_a = dot_q;
				mul_b = mul_q[32:0];
			end
			default: ;
		endcase
	end

	assign term_ext = {{(ACC_W - 34){mul_q[65]}}, mul_q[65:32]};

	always_ff @(posedge clk) begin
		mul_q <= mul_a * mul_b;
		case (state_q)
			ST_IDLE: begin
				if (eval_fire) begin
					pos_q[0] <= vec_a_x[15:0];
					pos_q[1] <= vec_a_y[15:0];
					pos_q[2] <= vec_a_z[15:0];
					dir_q[0] <= vec_b_x;
					dir_q[1] <= vec_b_y;
					dir_q[2] <= vec_b_z;
					n_q      <= n_d;
					m_q      <= '0;
					acc_q    <= '0;
				end
			end
			ST_PREP: begin
				x_q   <= CORDIC_X0;
				y_q   <= '0;
				z_q   <= tf;
				it_q  <= '0;
				dot_q <= '0;
			end
			ST_ROT: begin
				if (z_q >= 0) begin
					x_q <= x_q - sy;
					y_q <= y_q + sx;
					z_q <= z_q - ang;
				end else begin
					x_q <= x_q + sy;
					y_q <= y_q - sx;
					z_q <= z_q + ang;
				end
				it_q <= it_q + 1'b1;
				if ((it_q != '0) && (it_q <= ITER_W'(3))) begin
					dot_q <= dot_q + mul_q[32:0];
				end
			end
			ST_SINE: sine_q <= sine_d;
			ST_ACC: begin
				acc_q <= acc_q + term_ext + {{(ACC_W - 1){1'b0}}, mul_q[31]};
				m_q   <= m_q + 1'b1;
			end
			default: ;
		endcase
	end

	always_comb begin
		if (&acc_q[ACC_W-1:31] || ~|acc_q[ACC_W-1:31]) begin
			sat = acc_q[31:0];
		end else if (acc_q[ACC_W-1]) begin
			sat = 32'h8000_0000;
		end else begin
			sat = 32'h7fff_ffff;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done_fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_fire) begin
			potential_q <= sat;
		end
	end

endmodule
